>>> hdl/wpjm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpjm_pkg
// Shared constants, load codes and control structs of the Jacobian unit.
// ---------------------------------------------------------------------------
package wpjm_pkg;

  localparam int K_MAX   = 8;
  localparam int IDX_W   = 3;
  localparam int VAL_W   = 17;
  localparam int CFG_W   = 4;
  localparam int OUT_W   = 32;
  localparam int H_DEPTH = (K_MAX - 1) * K_MAX;
  localparam int H_AW    = $clog2(H_DEPTH);
  localparam int W_AW    = $clog2(K_MAX);
  localparam int P1_W    = 2 * VAL_W;
  localparam int P2_W    = P1_W + VAL_W;
  localparam int ACC_W   = P2_W + $clog2(K_MAX);

  localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_H      = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  // store write command, controller to datapath
  typedef struct packed {
    logic             wr_w;
    logic             wr_h;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] data;
  } load_cmd_t;

  // one multiply-accumulate term, travels down the datapath pipe
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_term;
    logic             last_entry;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [W_AW-1:0]  term;
  } issue_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

endpackage

>>> hdl/weighted_prob_jacobian_matrix_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_prob_jacobian_matrix_unit
// Loads w[k] and h[k-1][k] (Q1.16), then streams the (k-1)x(k-1) matrix
// D[l][l] = sum h(1-h)w, D[l][m] = -sum h[l]h[m]w as signed Q15.16 words.
// A load word leaves busy low.
// A start word issues (k-1)^2 * k MAC terms, one per cycle on the shared
// multiply pipe; each result word follows the last term of its entry down
// the datapath pipe, and busy stays high until the last word (last = 1),
// dropping the cycle after it.
// Reset: synchronous, active low; category_count returns to 8. Store
// contents are not cleared and must be loaded before a start.
// ---------------------------------------------------------------------------
module weighted_prob_jacobian_matrix_unit
  import wpjm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // command word: accepted when start && !busy
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_kind,
  input  logic [IDX_W-1:0] in_row_index,
  input  logic [IDX_W-1:0] in_col_index,
  input  logic [VAL_W-1:0] in_value,
  // category_count register
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  // result words, one cycle each, no backpressure
  output logic             out_strobe,
  output logic [IDX_W-1:0] out_row,
  output logic [IDX_W-1:0] out_col,
  output logic [OUT_W-1:0] out_value,
  output logic             out_last
);

  load_cmd_t  load_cmd;
  issue_t     issue;
  dp_status_t status;

  // Controller: decodes words, holds k, walks l, m, j.
  wpjm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_kind      (in_kind),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_value     (in_value),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .status       (status),
    .busy         (busy),
    .load_cmd     (load_cmd),
    .issue        (issue)
  );

  // Datapath: store reads (1), h*h' (2), *w (3), accumulate (4),
  // round/saturate into the output register (5).
  wpjm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_cmd   (load_cmd),
    .issue      (issue),
    .status     (status),
    .out_strobe (out_strobe),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

>>> hdl/wpjm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpjm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wpjm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/wpjm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpjm_ctrl
// Command decode, category register and the (l, m, j) term sequencer.
// ---------------------------------------------------------------------------
module wpjm_ctrl
  import wpjm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_kind,
  input  logic [IDX_W-1:0] in_row_index,
  input  logic [IDX_W-1:0] in_col_index,
  input  logic [VAL_W-1:0] in_value,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  dp_status_t       status,
  output logic             busy,
  output load_cmd_t        load_cmd,
  output issue_t           issue
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t           state_r;
  logic             busy_r;
  logic [CFG_W-1:0] cfg_r;
  logic [IDX_W-1:0] l_r;
  logic [IDX_W-1:0] m_r;
  logic [W_AW-1:0]  j_r;
  logic [W_AW-1:0]  jmax_r;
  logic [IDX_W-1:0] smax_r;
  logic [CFG_W-1:0] k_eff;
  logic             accept;
  logic             last_term;
  logic             last_entry;

  assign accept = start && !busy_r;

  always_comb begin
    priority if (cfg_r < CFG_W'(2)) begin
      k_eff = CFG_W'(2);
    end else if (cfg_r > CFG_W'(K_MAX)) begin
      k_eff = CFG_W'(K_MAX);
    end else begin
      k_eff = cfg_r;
    end
  end

  // out-of-range load addresses are dropped
  always_comb begin
    load_cmd.wr_w = accept && (in_kind == KIND_WEIGHT) && (int'(in_col_index) < K_MAX);
    load_cmd.wr_h = accept && (in_kind == KIND_H) && (int'(in_row_index) < K_MAX - 1)
                    && (int'(in_col_index) < K_MAX);
    load_cmd.row  = in_row_index;
    load_cmd.col  = in_col_index;
    load_cmd.data = in_value;
  end

  assign last_term  = (j_r == jmax_r);
  assign last_entry = (l_r == smax_r) && (m_r == smax_r);

  always_comb begin
    issue.valid      = (state_r == S_RUN);
    issue.first      = (j_r == '0);
    issue.last_term  = last_term;
    issue.last_entry = last_entry;
    issue.row        = l_r;
    issue.col        = m_r;
    issue.term       = j_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      cfg_r   <= CFG_W'(K_MAX);
      l_r     <= '0;
      m_r     <= '0;
      j_r     <= '0;
      jmax_r  <= '0;
      smax_r  <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_kind == KIND_START)) begin
            state_r <= S_RUN;
            busy_r  <= 1'b1;
            l_r     <= '0;
            m_r     <= '0;
            j_r     <= '0;
            jmax_r  <= W_AW'(k_eff - CFG_W'(1));
            smax_r  <= IDX_W'(k_eff - CFG_W'(2));
          end
        end
        S_RUN: begin
          if (last_term) begin
            j_r <= '0;
            if (m_r == smax_r) begin
              m_r <= '0;
              l_r <= l_r + IDX_W'(1);
              if (l_r == smax_r) begin
                state_r <= S_DRAIN;
              end
            end else begin
              m_r <= m_r + IDX_W'(1);
            end
          end else begin
            j_r <= j_r + W_AW'(1);
          end
        end
        S_DRAIN: begin
          if (status.done) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_r;

endmodule

>>> hdl/wpjm_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wpjm_dpath
// Stores, two-step product pipe, accumulator and round/saturate stage.
// ---------------------------------------------------------------------------
module wpjm_dpath
  import wpjm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  load_cmd_t        load_cmd,
  input  issue_t           issue,
  output dp_status_t       status,
  output logic             out_strobe,
  output logic [IDX_W-1:0] out_row,
  output logic [IDX_W-1:0] out_col,
  output logic [OUT_W-1:0] out_value,
  output logic             out_last
);

  logic [VAL_W-1:0] wdata_sat;
  logic [W_AW-1:0]  w_waddr;
  logic [H_AW-1:0]  h_waddr;
  logic [W_AW-1:0]  w_raddr;
  logic [H_AW-1:0]  hl_raddr;
  logic [H_AW-1:0]  hm_raddr;
  logic [VAL_W-1:0] w_q;
  logic [VAL_W-1:0] hl_q;
  logic [VAL_W-1:0] hm_q;
  logic [VAL_W-1:0] opnd;

  issue_t           s1_r, s2_r, s3_r, s4_r;
  logic [P1_W-1:0]  p1_r;
  logic [VAL_W-1:0] w2_r;
  logic [P2_W-1:0]  p2_r;
  logic [ACC_W-1:0] acc_r;

  logic [ACC_W:0]   rnd_sum;
  logic [32:0]      mag;
  logic [OUT_W-1:0] val_nxt;

  logic             out_strobe_r;
  logic [IDX_W-1:0] out_row_r;
  logic [IDX_W-1:0] out_col_r;
  logic [OUT_W-1:0] out_value_r;
  logic             out_last_r;

  // loads clip to one
  assign wdata_sat = (load_cmd.data > ONE_Q16) ? ONE_Q16 : load_cmd.data;
  assign w_waddr   = W_AW'(load_cmd.col);
  assign h_waddr   = H_AW'(int'(load_cmd.row) * K_MAX + int'(load_cmd.col));
  assign w_raddr   = issue.term;
  assign hl_raddr  = H_AW'(int'(issue.row) * K_MAX + int'(issue.term));
  assign hm_raddr  = H_AW'(int'(issue.col) * K_MAX + int'(issue.term));

  wpjm_ram #(.WIDTH(VAL_W), .DEPTH(K_MAX)) u_w_ram (
    .clk   (clk),
    .we    (load_cmd.wr_w),
    .waddr (w_waddr),
    .wdata (wdata_sat),
    .raddr (w_raddr),
    .rdata (w_q)
  );

  // h is kept twice so row l and row m are read in the same cycle
  wpjm_ram #(.WIDTH(VAL_W), .DEPTH(H_DEPTH)) u_hl_ram (
    .clk   (clk),
    .we    (load_cmd.wr_h),
    .waddr (h_waddr),
    .wdata (wdata_sat),
    .raddr (hl_raddr),
    .rdata (hl_q)
  );

  wpjm_ram #(.WIDTH(VAL_W), .DEPTH(H_DEPTH)) u_hm_ram (
    .clk   (clk),
    .we    (load_cmd.wr_h),
    .waddr (h_waddr),
    .wdata (wdata_sat),
    .raddr (hm_raddr),
    .rdata (hm_q)
  );

  // diagonal uses 1 - h[l][j] in place of h[m][j]
  assign opnd = (s1_r.row == s1_r.col) ? VAL_W'(ONE_Q16 - hl_q) : hm_q;

  // round half away from zero on the magnitude, then clamp
  assign rnd_sum = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(64'h8000_0000);
  assign mag     = 33'(rnd_sum >> 32);

  always_comb begin
    if (s4_r.row == s4_r.col) begin
      val_nxt = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      val_nxt = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r         <= '0;
      s2_r         <= '0;
      s3_r         <= '0;
      s4_r         <= '0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      s1_r         <= issue;
      s2_r         <= s1_r;
      s3_r         <= s2_r;
      s4_r         <= s3_r;
      out_strobe_r <= s4_r.valid && s4_r.last_term;
      out_last_r   <= s4_r.valid && s4_r.last_term && s4_r.last_entry;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= P1_W'(hl_q) * P1_W'(opnd);
    w2_r <= w_q;
    p2_r <= P2_W'(p1_r) * P2_W'(w2_r);
    if (s3_r.valid) begin
      acc_r <= s3_r.first ? ACC_W'(p2_r) : acc_r + ACC_W'(p2_r);
    end
    out_row_r   <= s4_r.row;
    out_col_r   <= s4_r.col;
    out_value_r <= val_nxt;
  end

  assign status.done = out_strobe_r && out_last_r;
  assign out_strobe  = out_strobe_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_value   = out_value_r;
  assign out_last    = out_last_r;

endmodule

>>> bench/tb_weighted_prob_jacobian_matrix_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_weighted_prob_jacobian_matrix_unit
// Self-checking bench for the weighted-probability Jacobian unit. Command
// words (weight loads, h loads, starts, junk) flow from a queue through a
// clocked driver with random idle bursts. Every accepted word is folded into
// a local copy of both stores, and each start expands into the full set of
// expected matrix entries, compared field by field as the unit emits them.
// Runs over many category counts, including the clamped ones.
// ---------------------------------------------------------------------------
module tb_weighted_prob_jacobian_matrix_unit;
  import wpjm_pkg::*;

  // kind code the unit must drop on the floor
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int PHASES = 12;

  typedef struct {
    logic [1:0]       kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } cmd_word_t;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [OUT_W-1:0] value;
    logic             last;
  } entry_t;

  // all inputs start known
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_kind = KIND_WEIGHT;
  logic [IDX_W-1:0] in_row_index = '0;
  logic [IDX_W-1:0] in_col_index = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             out_strobe;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic [OUT_W-1:0] out_value;
  logic             out_last;

  weighted_prob_jacobian_matrix_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_value     (in_value),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_strobe   (out_strobe),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .out_last     (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the unit's stores and its one register
  logic [VAL_W-1:0] weight_mem [K_MAX];
  logic [VAL_W-1:0] hprob_mem  [H_DEPTH];
  logic [CFG_W-1:0] cat_count = CFG_W'(8);

  cmd_word_t pending_words[$];
  entry_t    expected_entries[$];

  // generator-side bookkeeping: which entries hold a defined value
  bit w_loaded [K_MAX];
  bit h_loaded [H_DEPTH];

  bit sender_idle_en = 1'b1;
  int gap_left = 0;
  int fail_count = 0;
  int checked_count = 0;
  int start_count = 0;
  int live_count = 0;

  // category count as the unit sees it: clamped to 2..K_MAX
  function automatic int eff_k(logic [CFG_W-1:0] c);
    if (c < 2) return 2;
    if (c > K_MAX) return K_MAX;
    return int'(c);
  endfunction

  // Q.48 magnitude -> Q.16, round half away from zero, sign, saturate
  function automatic logic [OUT_W-1:0] round_q16(logic [63:0] mag, bit neg);
    logic [63:0] r;
    logic [63:0] neg_r;
    r = (mag + 64'h8000_0000) >> 32;
    if (!neg) return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    if (r > 64'h8000_0000) r = 64'h8000_0000;
    neg_r = -r;
    return neg_r[31:0];
  endfunction

  // fold one accepted word into the shadow stores; a start queues the
  // whole (k-1)x(k-1) matrix in row-major order
  task automatic absorb_word(cmd_word_t w);
    int k;
    logic [63:0] acc;
    logic [63:0] hl;
    logic [63:0] wt;
    logic [VAL_W-1:0] v;
    entry_t e;
    v = (w.value > ONE_Q16) ? ONE_Q16 : w.value;   // loads clip at one
    case (w.kind)
      KIND_WEIGHT: weight_mem[w.col] = v;
      KIND_H: if (w.row < K_MAX - 1) hprob_mem[w.row * K_MAX + w.col] = v;
      KIND_START: begin
        k = eff_k(cat_count);
        for (int l = 0; l < k - 1; l++) begin
          for (int m = 0; m < k - 1; m++) begin
            acc = '0;
            for (int j = 0; j < k; j++) begin
              hl = 64'(hprob_mem[l * K_MAX + j]);
              wt = 64'(weight_mem[j]);
              if (l == m) acc += hl * (64'(ONE_Q16) - hl) * wt;
              else acc += hl * 64'(hprob_mem[m * K_MAX + j]) * wt;
            end
            e.row = IDX_W'(l);
            e.col = IDX_W'(m);
            e.value = round_q16(acc, l != m);
            e.last = (l == k - 2) && (m == k - 2);
            expected_entries.push_back(e);
          end
        end
        start_count++;
      end
      default: ;   // unused kind: no effect
    endcase
  endtask

  // ---- driver: one word per accept, random idle bursts between words ----
  always @(posedge clk) begin
    cmd_word_t taken;
    cmd_word_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        taken.kind = in_kind;
        taken.row = in_row_index;
        taken.col = in_col_index;
        taken.value = in_value;
        absorb_word(taken);
      end
      if (start && busy) begin
        // held: word stays on the bus until the unit takes it
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() != 0) begin
        nxt = pending_words.pop_front();
        in_kind <= nxt.kind;
        in_row_index <= nxt.row;
        in_col_index <= nxt.col;
        in_value <= nxt.value;
        start <= 1'b1;
        if (sender_idle_en && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 15);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---- monitor: every strobed word must match the oldest expectation ----
  always @(posedge clk) begin
    entry_t exp_e;
    if (rst_n && out_strobe) begin
      if (expected_entries.size() == 0) begin
        $error("unexpected result word: row %0d col %0d value %0d", out_row, out_col,
               $signed(out_value));
        fail_count++;
      end else begin
        exp_e = expected_entries.pop_front();
        if (out_row !== exp_e.row) begin
          $error("out_row mismatch: expected %0d, actual %0d", exp_e.row, out_row);
          fail_count++;
        end
        if (out_col !== exp_e.col) begin
          $error("out_col mismatch: expected %0d, actual %0d", exp_e.col, out_col);
          fail_count++;
        end
        if (out_value !== exp_e.value) begin
          $error("out_value mismatch: expected %0d, actual %0d", $signed(exp_e.value),
                 $signed(out_value));
          fail_count++;
        end
        if (out_last !== exp_e.last) begin
          $error("out_last mismatch: expected %0d, actual %0d", exp_e.last, out_last);
          fail_count++;
        end
        checked_count++;
      end
    end
  end

  // mostly in-range probabilities, a few exact ends, a few above one
  function automatic logic [VAL_W-1:0] rand_prob();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE_Q16;
      2: return VAL_W'($urandom);
      default: return VAL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic queue_word(logic [1:0] kind, int row, int col, logic [VAL_W-1:0] value);
    cmd_word_t w;
    w.kind = kind;
    w.row = IDX_W'(row);
    w.col = IDX_W'(col);
    w.value = value;
    pending_words.push_back(w);
    if (kind == KIND_WEIGHT) w_loaded[col] = 1'b1;
    else if (kind == KIND_H && row < K_MAX - 1) h_loaded[row * K_MAX + col] = 1'b1;
    // dropped words do not count as real traffic
    if (kind == KIND_WEIGHT || kind == KIND_START || (kind == KIND_H && row < K_MAX - 1))
      live_count++;
  endtask

  // a start only after every entry it reads has been loaded
  task automatic queue_start(int k, bit use_max);
    for (int j = 0; j < k; j++) begin
      if (!w_loaded[j])
        queue_word(KIND_WEIGHT, $urandom_range(0, 7), j, use_max ? ONE_Q16 : rand_prob());
      for (int r = 0; r < k - 1; r++)
        if (!h_loaded[r * K_MAX + j])
          queue_word(KIND_H, r, j, use_max ? ONE_Q16 : rand_prob());
    end
    queue_word(KIND_START, $urandom_range(0, 7), $urandom_range(0, 7), VAL_W'($urandom));
  endtask

  // all words taken, all results seen, unit idle, plus a latency margin
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || start || busy || expected_entries.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_categories(logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cat_count = v;
  endtask

  // ---- stimulus ----
  initial begin
    logic [CFG_W-1:0] cfg_list [PHASES];
    int k;
    int target;
    int pick;
    cfg_list = '{4'd2, 4'd0, 4'd5, 4'd15, 4'd3, 4'd1, 4'd8, 4'd6, 4'd9, 4'd4, 4'd7, 4'd8};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset count (8): every entry at one -> zero diagonal, full negative
    queue_start(K_MAX, 1'b1);
    // directed corners at k = 8
    queue_word(KIND_H, 7, 3, 17'd12345);        // row past last h row: dropped
    queue_word(KIND_NONE, 5, 5, 17'h1FFFF);     // unused kind
    queue_word(KIND_WEIGHT, 0, 0, 17'h1FFFF);   // above one, clips
    queue_word(KIND_H, 0, 7, 17'd65537);
    queue_word(KIND_H, 6, 0, 17'd0);
    queue_word(KIND_H, 0, 0, 17'd32768);        // peak of h(1-h)
    queue_word(KIND_H, 1, 1, 17'd1);
    queue_word(KIND_WEIGHT, 2, 7, 17'd0);
    queue_word(KIND_WEIGHT, 5, 3, 17'd1);
    queue_start(K_MAX, 1'b0);
    queue_word(KIND_H, 7, 7, 17'h1FFFF);
    queue_word(KIND_NONE, 0, 0, 17'd0);
    queue_start(K_MAX, 1'b0);

    // random phases, one category setting each; last phase runs without gaps
    for (int p = 0; p < PHASES; p++) begin
      set_categories(cfg_list[p]);
      k = eff_k(cfg_list[p]);
      sender_idle_en = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      target = live_count + 12;
      while (live_count < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          queue_start(k, 1'b0);
        end else if (pick < 14) begin
          if ($urandom_range(0, 1) == 0)
            queue_word(KIND_NONE, $urandom_range(0, 7), $urandom_range(0, 7), VAL_W'($urandom));
          else
            queue_word(KIND_H, 7, $urandom_range(0, 7), VAL_W'($urandom));
        end else if (pick < 17) begin
          // fresh full set for this k, then compute
          for (int j = 0; j < k; j++) begin
            queue_word(KIND_WEIGHT, $urandom_range(0, 7), j, rand_prob());
            for (int r = 0; r < k - 1; r++) queue_word(KIND_H, r, j, rand_prob());
          end
          queue_start(k, 1'b0);
        end else if ($urandom_range(0, 2) == 0) begin
          queue_word(KIND_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 7), rand_prob());
        end else begin
          queue_word(KIND_H, $urandom_range(0, 6), $urandom_range(0, 7), rand_prob());
        end
      end
      queue_start(k, 1'b0);
    end

    // drain: all words taken, then a bounded wait for the matrix tail
    do @(posedge clk);
    while (pending_words.size() != 0 || start);
    for (int n = 0; n < 1000 && (expected_entries.size() != 0 || busy); n++) @(posedge clk);
    repeat (12) @(posedge clk);
    if (expected_entries.size() != 0) begin
      $error("%0d expected matrix entries never arrived", expected_entries.size());
      fail_count++;
    end

    $display("run covered %0d live command words, %0d starts, %0d category settings",
             live_count, start_count, PHASES + 1);
    $display("%0d matrix entries compared, %0d field errors", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("weighted_prob_jacobian_matrix_unit regression: pass");
    end else begin
      $display("weighted_prob_jacobian_matrix_unit regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("weighted_prob_jacobian_matrix_unit regression: fail");
    $finish;
  end

endmodule
